// File: hw/rtl/cmfs_pkg.sv
// shared types, constants and face codes for the cube map face selector
package cmfs_pkg;

    localparam int COMP_WIDTH = 16;
    localparam int QUO_WIDTH  = COMP_WIDTH - 1;
    localparam int NUM_CELLS  = COMP_WIDTH - 1;

    localparam logic [2:0] FACE_POS_X = 3'd0;
    localparam logic [2:0] FACE_NEG_X = 3'd1;
    localparam logic [2:0] FACE_POS_Y = 3'd2;
    localparam logic [2:0] FACE_NEG_Y = 3'd3;
    localparam logic [2:0] FACE_POS_Z = 3'd4;
    localparam logic [2:0] FACE_NEG_Z = 3'd5;

    typedef struct packed {
        logic signed [COMP_WIDTH-1:0] dir_x;
        logic signed [COMP_WIDTH-1:0] dir_y;
        logic signed [COMP_WIDTH-1:0] dir_z;
    } dir_t;

    typedef struct packed {
        logic [2:0]                   face_index;
        logic signed [COMP_WIDTH-1:0] coord_u;
        logic signed [COMP_WIDTH-1:0] coord_v;
        logic                         zero_vector;
    } result_t;

    // work carried down the divider chain
    typedef struct packed {
        logic [2:0]            face;
        logic                  zero;
        logic                  sign_u;
        logic                  sign_v;
        logic [COMP_WIDTH-1:0] divisor;
        logic [COMP_WIDTH-1:0] rem_u;
        logic [COMP_WIDTH-1:0] rem_v;
        logic [QUO_WIDTH-1:0]  quo_u;
        logic [QUO_WIDTH-1:0]  quo_v;
    } stage_t;

endpackage

// File: hw/rtl/cmfs_front.sv
// input stage: major axis pick, face code, minor magnitudes and signs
module cmfs_front
    import cmfs_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_stall,
    input  dir_t   in_data,
    output logic   out_valid,
    output stage_t out_data,
    input  logic   out_ready
);

    logic   valid_reg;
    logic   valid_next;
    stage_t data_reg;
    stage_t data_next;
    logic   load;

    logic [COMP_WIDTH-1:0] ax, ay, az;
    logic                  xneg, yneg, zneg;
    logic                  xpos, ypos, zpos;

    assign load       = !valid_reg || out_ready;
    assign in_stall   = !load;
    assign valid_next = in_valid;

    always_comb
    begin
        xneg = in_data.dir_x[COMP_WIDTH-1];
        yneg = in_data.dir_y[COMP_WIDTH-1];
        zneg = in_data.dir_z[COMP_WIDTH-1];
        xpos = !xneg && (in_data.dir_x != '0);
        ypos = !yneg && (in_data.dir_y != '0);
        zpos = !zneg && (in_data.dir_z != '0);
        // two's complement magnitude, most negative value maps exactly
        ax = xneg ? (~in_data.dir_x + 1'b1) : in_data.dir_x;
        ay = yneg ? (~in_data.dir_y + 1'b1) : in_data.dir_y;
        az = zneg ? (~in_data.dir_z + 1'b1) : in_data.dir_z;

        data_next       = '0;
        data_next.zero  = (in_data.dir_x == '0) && (in_data.dir_y == '0)
                          && (in_data.dir_z == '0);
        data_next.quo_u = '0;
        data_next.quo_v = '0;

        priority if (ax >= ay && ax >= az)
        begin
            data_next.divisor = ax;
            data_next.rem_u   = az;
            data_next.rem_v   = ay;
            data_next.sign_v  = ypos;
            if (!xneg)
            begin
                data_next.face   = FACE_POS_X;
                data_next.sign_u = zpos;
            end
            else
            begin
                data_next.face   = FACE_NEG_X;
                data_next.sign_u = zneg;
            end
        end
        else if (ay >= az)
        begin
            data_next.divisor = ay;
            data_next.rem_u   = ax;
            data_next.rem_v   = az;
            data_next.sign_u  = xneg;
            if (!yneg)
            begin
                data_next.face   = FACE_POS_Y;
                data_next.sign_v = zneg;
            end
            else
            begin
                data_next.face   = FACE_NEG_Y;
                data_next.sign_v = zpos;
            end
        end
        else
        begin
            data_next.divisor = az;
            data_next.rem_u   = ax;
            data_next.rem_v   = ay;
            data_next.sign_v  = ypos;
            if (!zneg)
            begin
                data_next.face   = FACE_POS_Z;
                data_next.sign_u = xneg;
            end
            else
            begin
                data_next.face   = FACE_NEG_Z;
                data_next.sign_u = xpos;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// File: hw/rtl/cmfs_div_cell.sv
// one restoring division cell: one quotient bit for both u and v
module cmfs_div_cell
    import cmfs_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_ready,
    input  stage_t in_data,
    output logic   out_valid,
    output stage_t out_data,
    input  logic   out_ready
);

    logic   valid_reg;
    stage_t data_reg;
    stage_t data_next;
    logic   load;

    logic [COMP_WIDTH:0]   diff_u, diff_v;
    logic                  bit_u, bit_v;
    logic [COMP_WIDTH-1:0] part_u, part_v;

    assign load     = !valid_reg || out_ready;
    assign in_ready = load;

    always_comb
    begin
        diff_u = {1'b0, in_data.rem_u} - {1'b0, in_data.divisor};
        diff_v = {1'b0, in_data.rem_v} - {1'b0, in_data.divisor};
        bit_u  = !diff_u[COMP_WIDTH];
        bit_v  = !diff_v[COMP_WIDTH];
        part_u = bit_u ? diff_u[COMP_WIDTH-1:0] : in_data.rem_u;
        part_v = bit_v ? diff_v[COMP_WIDTH-1:0] : in_data.rem_v;

        data_next       = in_data;
        // remainder stays below the divisor, so doubling fits
        data_next.rem_u = {part_u[COMP_WIDTH-2:0], 1'b0};
        data_next.rem_v = {part_v[COMP_WIDTH-2:0], 1'b0};
        data_next.quo_u = {in_data.quo_u[QUO_WIDTH-2:0], bit_u};
        data_next.quo_v = {in_data.quo_v[QUO_WIDTH-2:0], bit_v};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// File: hw/rtl/cmfs_back.sv
// output stage: quotient sign, zero vector override, result register
module cmfs_back
    import cmfs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  stage_t  in_data,
    output logic    res_valid,
    input  logic    res_stall,
    output result_t res_data
);

    logic    valid_reg;
    result_t data_reg;
    result_t data_next;
    logic    load;

    logic [COMP_WIDTH-1:0] mag_u, mag_v;

    assign load     = !valid_reg || !res_stall;
    assign in_ready = load;

    always_comb
    begin
        mag_u = {1'b0, in_data.quo_u};
        mag_v = {1'b0, in_data.quo_v};

        data_next.face_index  = in_data.face;
        data_next.zero_vector = in_data.zero;
        data_next.coord_u     = in_data.sign_u ? (~mag_u + 1'b1) : mag_u;
        data_next.coord_v     = in_data.sign_v ? (~mag_v + 1'b1) : mag_v;
        if (in_data.zero)
        begin
            data_next.coord_u = '0;
            data_next.coord_v = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign res_valid = valid_reg;
    assign res_data  = data_reg;

endmodule

// File: hw/rtl/cube_map_face_select.sv
// throughput: one transfer per cycle while res_stall is low, set by the chain of one-bit division cells
// each stage holds one item and loads when empty, so a stalled result reaches back only
// through stages that are full
// reset: asynchronous active low, clears the valid flag of every stage only
// an all-zero vector gives face 0, u and v zero and zero_vector set
module cube_map_face_select
    import cmfs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    dir_valid,
    output logic    dir_stall,
    input  dir_t    dir_data,
    output logic    res_valid,
    input  logic    res_stall,
    output result_t res_data
);

    // stage k feeds cell k; stage NUM_CELLS feeds the output stage
    logic   stage_valid [NUM_CELLS+1];
    logic   stage_ready [NUM_CELLS+1];
    stage_t stage_data  [NUM_CELLS+1];

    // major axis, face code, minor magnitudes and quotient signs
    cmfs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dir_valid),
        .in_stall  (dir_stall),
        .in_data   (dir_data),
        .out_valid (stage_valid[0]),
        .out_data  (stage_data[0]),
        .out_ready (stage_ready[0])
    );

    // one quotient bit per cell, msb first; both minor axes share the divisor
    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        cmfs_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stage_valid[i]),
            .in_ready  (stage_ready[i]),
            .in_data   (stage_data[i]),
            .out_valid (stage_valid[i+1]),
            .out_data  (stage_data[i+1]),
            .out_ready (stage_ready[i+1])
        );
    end

    // apply signs, override the all-zero case, hold the result for transfer
    cmfs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (stage_valid[NUM_CELLS]),
        .in_ready  (stage_ready[NUM_CELLS]),
        .in_data   (stage_data[NUM_CELLS]),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

endmodule
